>>> sv/pgts_pkg.sv
// ----------------------------------------------------------------------------
// pgts_pkg: shared types and constants of the probe grid sampler
// Commands, register indexes, controller states and fixed-point constants.
// ----------------------------------------------------------------------------
package pgts_pkg;

    localparam int CMD_W   = 2;
    localparam int POS_W   = 32;
    localparam int VAL_W   = 16;
    localparam int PIDX_W  = 6;
    localparam int CNT_REG_W = 7;
    localparam int EXT_W   = 29;
    localparam int DEN_W   = 30;
    localparam int FRAC_W  = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [VAL_W-1:0] ONE_Q15    = 16'h8000;
    localparam logic [EXT_W-1:0] EXTENT_MIN = 29'd655;
    localparam logic [EXT_W-1:0] EXTENT_MAX = 29'd268435456;
    localparam logic [EXT_W-1:0] EXTENT_RST = 29'd65536;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNT_X  = 3'd0,
        REG_COUNT_Y  = 3'd1,
        REG_COUNT_Z  = 3'd2,
        REG_EXTENT_X = 3'd3,
        REG_EXTENT_Y = 3'd4,
        REG_EXTENT_Z = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMD,
        S_AXIS,
        S_MUL,
        S_DGO,
        S_DWAIT,
        S_IDX_A,
        S_IDX_B,
        S_MEM,
        S_MEM_WAIT,
        S_BLEND,
        S_EMIT
    } t_state;

endpackage

>>> sv/probe_grid_trilinear_sampler.sv
// ----------------------------------------------------------------------------
// probe_grid_trilinear_sampler: 3D occlusion probe grid with trilinear lookup
// Stores Q1.15 probes in one RAM and answers read and sample commands.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid/o_in_ready) carries one command per transfer:
//    write probe, read probe, sample at a Q16.16 position, or clear.
//  - Output channel (o_out_valid/i_out_ready) returns one Q1.15 value for
//    read and sample; write and clear return nothing.
//  - Config channel (i_cfg_valid/o_cfg_ready) sets counts and extents; it is
//    always ready. The user must write it only while the block is idle;
//    the block itself does not enforce this.
//  - One command at a time. For a sample, each axis runs a bit-serial
//    divider for the cell index and 16 fraction bits, then eight corner
//    reads share the single RAM port, then seven blends share one blend
//    unit.
//  - Reset returns counts to 1 and extents to 1.0 and drops the loaded flag;
//    the RAM contents are not cleared and need no clearing pass.
//  - A result waits in the output register while the receiver stalls; the
//    controller holds in its emit state until that register frees up.
// ----------------------------------------------------------------------------
module probe_grid_trilinear_sampler
    import pgts_pkg::*;
#(
    parameter int AXIS_MAX    = 64,
    parameter int STORE_DEPTH = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [PIDX_W-1:0]     i_probe_x,
    input  logic [PIDX_W-1:0]     i_probe_y,
    input  logic [PIDX_W-1:0]     i_probe_z,
    input  logic [VAL_W-1:0]      i_write_value,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [VAL_W-1:0]      o_ao_value,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [EXT_W-1:0]      i_cfg_data
);

    localparam int CW   = $clog2(AXIS_MAX + 1);
    localparam int QW   = $clog2(AXIS_MAX);
    localparam int IW   = (QW > PIDX_W) ? QW : PIDX_W;
    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int TW   = CW + IW + 1;
    localparam int LW0  = 2 * CW + IW + 2;
    localparam int LW   = (LW0 > AW + 1) ? LW0 : AW + 1;
    localparam int GW   = DEN_W + QW;
    localparam int FW   = QW + FRAC_W;
    localparam int NW   = POS_W + 2;
    localparam int KW   = CW + PIDX_W;
    localparam logic [LW-1:0] DEPTH_L = LW'(STORE_DEPTH);

    // ---------------- configuration ----------------
    logic [CW-1:0]    r_cnt [3];
    logic [EXT_W-1:0] r_ext [3];
    logic             r_loaded;

    logic [CW-1:0]    cfg_cnt;
    logic [EXT_W-1:0] cfg_ext;
    logic             cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    // clamp to the legal range before storing
    always_comb begin
        if (i_cfg_data[CNT_REG_W-1:0] == '0) begin
            cfg_cnt = CW'(1);
        end else if ({2'b00, i_cfg_data[CNT_REG_W-1:0]} > 9'(AXIS_MAX)) begin
            cfg_cnt = CW'(AXIS_MAX);
        end else begin
            cfg_cnt = CW'(i_cfg_data[CNT_REG_W-1:0]);
        end
        if (i_cfg_data < EXTENT_MIN) begin
            cfg_ext = EXTENT_MIN;
        end else if (i_cfg_data > EXTENT_MAX) begin
            cfg_ext = EXTENT_MAX;
        end else begin
            cfg_ext = i_cfg_data;
        end
    end

    // ---------------- command registers ----------------
    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [PIDX_W-1:0]     r_pidx [3];
    logic [VAL_W-1:0]      r_wval;
    logic signed [POS_W-1:0] r_pos [3];
    logic [1:0]            r_axis;
    logic [2:0]            r_corner;
    logic [2:0]            r_bstep;
    logic [DEN_W-1:0]      r_num;
    logic [GW-1:0]         r_g;
    logic [QW-1:0]         r_i0 [3];
    logic [QW-1:0]         r_i1 [3];
    logic [FRAC_W-1:0]     r_t [3];
    logic [TW-1:0]         r_t1;
    logic [LW-1:0]         r_idx;
    logic                  r_oob;
    logic [VAL_W-1:0]      r_v [8];
    logic [VAL_W-1:0]      r_res;
    logic                  r_out_valid;
    logic [VAL_W-1:0]      r_ao;

    logic in_xfer;
    logic out_free;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // ---------------- per-axis setup ----------------
    logic signed [POS_W-1:0] ax_pos;
    logic [EXT_W-1:0]        ax_ext;
    logic [CW-1:0]           ax_cnt;
    logic [QW-1:0]           ax_cm1;
    logic signed [NW-1:0]    ax_num;
    logic [DEN_W-1:0]        ax_den;
    logic                    ax_inside;
    logic [GW-1:0]           g_prod;

    assign ax_pos    = r_pos[r_axis];
    assign ax_ext    = r_ext[r_axis];
    assign ax_cnt    = r_cnt[r_axis];
    assign ax_cm1    = QW'(ax_cnt - CW'(1));
    assign ax_num    = {ax_pos[POS_W-1], ax_pos, 1'b0} + NW'(ax_ext);
    assign ax_den    = {ax_ext, 1'b0};
    assign ax_inside = !ax_num[NW-1] && (ax_num[NW-2:0] <= (NW-1)'(ax_den));
    assign g_prod    = {{QW{1'b0}}, r_num} * {{DEN_W{1'b0}}, ax_cm1};

    logic              div_start;
    logic              div_done;
    logic [FW-1:0]     div_quot;
    logic [QW-1:0]     dq_i0;

    assign dq_i0 = div_quot[FW-1:FRAC_W];

    pgts_div #(.QW(QW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_g),
        .i_divisor  (ax_den),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // ---------------- index computation ----------------
    logic [IW-1:0] ix, iy, iz;
    logic          probe_inside;

    always_comb begin
        if (r_cmd == CMD_SAMPLE) begin
            ix = IW'(r_corner[0] ? r_i1[0] : r_i0[0]);
            iy = IW'(r_corner[1] ? r_i1[1] : r_i0[1]);
            iz = IW'(r_corner[2] ? r_i1[2] : r_i0[2]);
        end else begin
            ix = IW'(r_pidx[0]);
            iy = IW'(r_pidx[1]);
            iz = IW'(r_pidx[2]);
        end
    end

    assign probe_inside = (KW'(r_pidx[0]) < KW'(r_cnt[0])) &&
                          (KW'(r_pidx[1]) < KW'(r_cnt[1])) &&
                          (KW'(r_pidx[2]) < KW'(r_cnt[2]));

    // ---------------- RAM ----------------
    logic             ram_we;
    logic [VAL_W-1:0] ram_rdata;
    logic [VAL_W-1:0] mem_val;

    pgts_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (r_idx[AW-1:0]),
        .i_wdata (r_wval),
        .o_rdata (ram_rdata)
    );

    assign mem_val = r_oob ? ONE_Q15 : ram_rdata;

    // ---------------- blend unit ----------------
    logic [VAL_W-1:0]  bl_a, bl_b;
    logic [FRAC_W-1:0] bl_t;
    logic [32:0]       bl_sum;
    logic [VAL_W-1:0]  bl_res;

    always_comb begin
        case (r_bstep)
            3'd0:    begin bl_a = r_v[0]; bl_b = r_v[1]; bl_t = r_t[0]; end
            3'd1:    begin bl_a = r_v[2]; bl_b = r_v[3]; bl_t = r_t[0]; end
            3'd2:    begin bl_a = r_v[4]; bl_b = r_v[5]; bl_t = r_t[0]; end
            3'd3:    begin bl_a = r_v[6]; bl_b = r_v[7]; bl_t = r_t[0]; end
            3'd4:    begin bl_a = r_v[0]; bl_b = r_v[1]; bl_t = r_t[1]; end
            3'd5:    begin bl_a = r_v[2]; bl_b = r_v[3]; bl_t = r_t[1]; end
            default: begin bl_a = r_v[0]; bl_b = r_v[1]; bl_t = r_t[2]; end
        endcase
    end

    assign bl_sum = (33'(bl_a) * (33'(17'h10000) - 33'(bl_t))) + (33'(bl_b) * 33'(bl_t));
    assign bl_res = bl_sum[31:16];

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) n_state = S_CMD;
            end
            S_CMD: begin
                case (r_cmd)
                    CMD_WRITE:  n_state = probe_inside ? S_IDX_A : S_IDLE;
                    CMD_READ:   n_state = (r_loaded && probe_inside) ? S_IDX_A : S_EMIT;
                    CMD_SAMPLE: n_state = r_loaded ? S_AXIS : S_EMIT;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_AXIS:  n_state = ax_inside ? S_MUL : S_EMIT;
            S_MUL:   n_state = S_DGO;
            S_DGO:   n_state = S_DWAIT;
            S_DWAIT: begin
                if (div_done) n_state = (r_axis == 2'd2) ? S_IDX_A : S_AXIS;
            end
            S_IDX_A: n_state = S_IDX_B;
            S_IDX_B: n_state = S_MEM;
            S_MEM:   n_state = (r_cmd == CMD_WRITE) ? S_IDLE : S_MEM_WAIT;
            S_MEM_WAIT: begin
                if (r_cmd == CMD_READ) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = (r_corner == 3'd7) ? S_BLEND : S_IDX_A;
                end
            end
            S_BLEND: begin
                if (r_bstep == 3'd6) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        div_start  = (r_state == S_DGO);
        ram_we     = (r_state == S_MEM) && (r_cmd == CMD_WRITE) && (r_idx < DEPTH_L);
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_loaded    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_cnt[a] <= CW'(1);
                r_ext[a] <= EXTENT_RST;
            end
        end else begin
            r_state <= n_state;

            // a count change that alters the effective value drops the grid
            if (cfg_we) begin
                case (i_cfg_index)
                    REG_COUNT_X: begin
                        if (cfg_cnt != r_cnt[0]) r_loaded <= 1'b0;
                        r_cnt[0] <= cfg_cnt;
                    end
                    REG_COUNT_Y: begin
                        if (cfg_cnt != r_cnt[1]) r_loaded <= 1'b0;
                        r_cnt[1] <= cfg_cnt;
                    end
                    REG_COUNT_Z: begin
                        if (cfg_cnt != r_cnt[2]) r_loaded <= 1'b0;
                        r_cnt[2] <= cfg_cnt;
                    end
                    REG_EXTENT_X: r_ext[0] <= cfg_ext;
                    REG_EXTENT_Y: r_ext[1] <= cfg_ext;
                    REG_EXTENT_Z: r_ext[2] <= cfg_ext;
                    default: ;
                endcase
            end

            if (r_state == S_CMD && r_cmd == CMD_CLEAR) r_loaded <= 1'b0;
            if (ram_we) r_loaded <= 1'b1;

            // hold the result while the receiver stalls
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd     <= t_cmd'(i_command);
            r_pidx[0] <= i_probe_x;
            r_pidx[1] <= i_probe_y;
            r_pidx[2] <= i_probe_z;
            r_wval    <= (i_write_value > ONE_Q15) ? ONE_Q15 : i_write_value;
            r_pos[0]  <= i_pos_x;
            r_pos[1]  <= i_pos_y;
            r_pos[2]  <= i_pos_z;
        end

        case (r_state)
            S_CMD: begin
                r_axis   <= 2'd0;
                r_corner <= 3'd0;
                r_bstep  <= 3'd0;
                r_res    <= ONE_Q15;
            end
            S_AXIS: begin
                r_num <= ax_num[DEN_W-1:0];
                r_res <= ONE_Q15;
            end
            S_MUL: r_g <= g_prod;
            S_DWAIT: begin
                if (div_done) begin
                    r_i0[r_axis] <= dq_i0;
                    r_i1[r_axis] <= (dq_i0 == ax_cm1) ? dq_i0 : dq_i0 + QW'(1);
                    r_t[r_axis]  <= div_quot[FRAC_W-1:0];
                    r_axis       <= r_axis + 2'd1;
                end
            end
            S_IDX_A: r_t1 <= TW'(iy) + TW'(r_cnt[1]) * TW'(iz);
            S_IDX_B: r_idx <= LW'(ix) + LW'(r_cnt[0]) * LW'(r_t1);
            S_MEM:   r_oob <= (r_idx >= DEPTH_L);
            S_MEM_WAIT: begin
                if (r_cmd == CMD_READ) begin
                    r_res <= mem_val;
                end else begin
                    r_v[r_corner] <= mem_val;
                    r_corner      <= r_corner + 3'd1;
                end
            end
            S_BLEND: begin
                // fold x pairs, then y pairs, then z
                case (r_bstep)
                    3'd0: r_v[0] <= bl_res;
                    3'd1: r_v[1] <= bl_res;
                    3'd2: r_v[2] <= bl_res;
                    3'd3: r_v[3] <= bl_res;
                    3'd4: r_v[0] <= bl_res;
                    3'd5: r_v[1] <= bl_res;
                    default: r_res <= bl_res;
                endcase
                r_bstep <= r_bstep + 3'd1;
            end
            S_EMIT: begin
                if (out_free) r_ao <= r_res;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_ao_value  = r_ao;

    // ---------------- assertions ----------------
    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_ao_value <= ONE_Q15))
        else $error("result above 1.0");

    a_write_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_loaded)
        else $error("store write did not set loaded flag");

    a_clear_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMD && r_cmd == CMD_CLEAR) |=> !r_loaded)
        else $error("clear did not drop loaded flag");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("emit did not load the output register");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DWAIT))
        else $error("divider finished outside its wait state");

endmodule

>>> sv/pgts_ram.sv
// ----------------------------------------------------------------------------
// pgts_ram: generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module pgts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/pgts_div.sv
// ----------------------------------------------------------------------------
// pgts_div: restoring divider for one axis
// Produces the cell index and a 16-bit fraction, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pgts_div
    import pgts_pkg::*;
#(
    parameter int QW = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [DEN_W+QW-1:0]    i_dividend,
    input  logic [DEN_W-1:0]       i_divisor,
    output logic                   o_done,
    output logic [QW+FRAC_W-1:0]   o_quot
);

    localparam int FW   = QW + FRAC_W;
    localparam int CNTW = $clog2(FW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNTW-1:0]   r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [FW-1:0]     r_shift;
    logic [FW-1:0]     r_quot;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    assign trial = {r_rem, r_shift[FW-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(FW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // the remainder stays below the divisor, so the integer part fits QW bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_dividend[DEN_W+QW-1:QW];
            r_shift <= {i_dividend[QW-1:0], {FRAC_W{1'b0}}};
            r_den   <= i_divisor;
            r_quot  <= '0;
        end else if (r_busy) begin
            r_rem   <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_shift <= {r_shift[FW-2:0], 1'b0};
            r_quot  <= {r_quot[FW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
